>>> src/sh32_pkg.sv
// Shared constants, command/status types and helpers for the streaming hash engine.
package sh32_pkg;

   // Hash primes
   localparam logic [31:0] PRIME1 = 32'h9E3779B1;
   localparam logic [31:0] PRIME2 = 32'h85EBCA77;
   localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
   localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
   localparam logic [31:0] PRIME5 = 32'h165667B1;

   localparam int unsigned LANE_COUNT  = 4;
   localparam int unsigned STRIPE_SIZE = 16;

   // Datapath micro-operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE  = 5'd0,
      OP_LOAD  = 5'd1,   // store request byte, count length
      OP_LMUL  = 5'd2,   // prod = stripe word * P2
      OP_LADD  = 5'd3,   // acc = rotl(lane + prod, 13)
      OP_LFIN  = 5'd4,   // lane = acc * P1
      OP_FOLD1 = 5'd5,   // start digest from lanes or seed
      OP_FOLD2 = 5'd6,   // add remaining lane rotations
      OP_FOLD3 = 5'd7,   // add total length
      OP_WMUL  = 5'd8,   // prod = leftover word * P3
      OP_WADD  = 5'd9,   // acc = rotl(acc + prod, 17)
      OP_WFIN  = 5'd10,  // acc = acc * P4
      OP_BMUL  = 5'd11,  // prod = leftover byte * P5
      OP_BADD  = 5'd12,  // acc = rotl(acc + prod, 11)
      OP_BFIN  = 5'd13,  // acc = acc * P1
      OP_AV1   = 5'd14,  // acc = (acc ^ acc >> 15) * P2
      OP_AV2   = 5'd15,  // acc = (acc ^ acc >> 13) * P3
      OP_EMIT  = 5'd16   // load result, restart message
   } sh32_op_type;

   typedef struct packed {
      sh32_op_type op;
      logic [3:0]  idx;   // byte position; [3:2] selects word and lane
   } sh32_cmd_type;

   typedef struct packed {
      logic [3:0] fill;   // bytes held in the stripe buffer
   } sh32_status_type;

   // Rotate left by a fixed amount in 1..31
   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
      rotl32 = (v << n) | (v >> (32 - n));
   endfunction

endpackage

>>> src/streaming_hash32_engine.sv
// Top level of the streaming 32-bit hash engine: controller plus datapath.
//
//  Channel | Ports                                              | Direction
//  --------+----------------------------------------------------+----------
//  req     | req_valid, req_stall, req_data_byte,               | in
//          | req_byte_present, req_end_of_message               |
//  rsp     | rsp_valid, rsp_stall, rsp_hash_value               | out
//  csr     | csr_write_enable, csr_write_data (seed)            | in
//
// The sixteenth byte of a stripe starts four lane rounds of three steps each on the one
// shared multiplier. A final request adds the fold steps, then multiply, add and finish
// per leftover word and byte, the avalanche steps and the emit, plus a wait while a
// previous result is still stalled on rsp. Reset is synchronous, active high; it clears
// the seed to zero and loads the lanes. req_stall is high whenever the controller is not
// idle; the result register lets the next message stream in while a finished hash waits.
module streaming_hash32_engine
   import sh32_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   sh32_cmd_type    cmd;
   sh32_status_type status;

   sh32_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .status             (status),
      .cmd                (cmd)
   );

   sh32_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data_byte    (req_data_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

>>> src/sh32_dpath.sv
// Datapath: stripe buffer, lanes, length, shared multiplier and result register.
module sh32_dpath
   import sh32_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [31:0]     csr_write_data,
   input  logic [7:0]      req_data_byte,
   input  sh32_cmd_type    cmd,
   output sh32_status_type status,
   output logic [31:0]     rsp_hash_value
);

   logic [31:0] seed_ff, seed_in;
   logic [31:0] lanes_ff [LANE_COUNT];
   logic [31:0] lanes_in [LANE_COUNT];
   logic [7:0]  buf_ff [STRIPE_SIZE];
   logic [3:0]  fill_ff, fill_in;
   logic [31:0] len_ff, len_in;
   logic        long_ff, long_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] hash_ff, hash_in;

   logic [1:0]  widx;
   logic [31:0] word_sel;
   logic [7:0]  byte_sel;
   logic [31:0] mul_a, mul_k, mul_res;
   logic [31:0] len_inc;
   logic        fresh;

   assign widx     = cmd.idx[3:2];
   assign word_sel = {buf_ff[{widx, 2'd3}], buf_ff[{widx, 2'd2}],
                      buf_ff[{widx, 2'd1}], buf_ff[{widx, 2'd0}]};
   assign byte_sel = buf_ff[cmd.idx];
   assign len_inc  = len_ff + 32'd1;
   assign fresh    = (fill_ff == 4'd0) && (len_ff == 32'd0) && !long_ff;

   // Select multiplier operands
   always_comb begin
      mul_a = acc_ff;
      mul_k = PRIME1;
      case (cmd.op)
         OP_LMUL: begin
            mul_a = word_sel;
            mul_k = PRIME2;
         end
         OP_WMUL: begin
            mul_a = word_sel;
            mul_k = PRIME3;
         end
         OP_WFIN: mul_k = PRIME4;
         OP_BMUL: begin
            mul_a = {24'd0, byte_sel};
            mul_k = PRIME5;
         end
         OP_AV1: begin
            mul_a = acc_ff ^ (acc_ff >> 15);
            mul_k = PRIME2;
         end
         OP_AV2: begin
            mul_a = acc_ff ^ (acc_ff >> 13);
            mul_k = PRIME3;
         end
         default: begin
            mul_a = acc_ff;
            mul_k = PRIME1;
         end
      endcase
   end

   assign mul_res = mul_a * mul_k;

   // Next-state logic for every datapath register but the stripe buffer
   always_comb begin
      seed_in = seed_ff;
      for (int i = 0; i < LANE_COUNT; i++) lanes_in[i] = lanes_ff[i];
      fill_in = fill_ff;
      len_in  = len_ff;
      long_in = long_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      hash_in = hash_ff;

      unique case (cmd.op) inside
         OP_NONE: ;
         OP_LOAD: begin
            fill_in = fill_ff + 4'd1;
            len_in  = len_inc;
            long_in = long_ff | (len_inc[31:4] != 28'd0);
         end
         OP_LMUL, OP_WMUL, OP_BMUL: prod_in = mul_res;
         OP_LADD: acc_in = rotl32(lanes_ff[widx] + prod_ff, 13);
         OP_LFIN: lanes_in[widx] = mul_res;
         OP_FOLD1: begin
            if (long_ff) begin
               acc_in = rotl32(lanes_ff[0], 1) + rotl32(lanes_ff[1], 7);
            end else begin
               acc_in = lanes_ff[2] + PRIME5;
            end
         end
         OP_FOLD2: begin
            if (long_ff) begin
               acc_in = acc_ff + rotl32(lanes_ff[2], 12) + rotl32(lanes_ff[3], 18);
            end
         end
         OP_FOLD3: acc_in = acc_ff + len_ff;
         OP_WADD:  acc_in = rotl32(acc_ff + prod_ff, 17);
         OP_BADD:  acc_in = rotl32(acc_ff + prod_ff, 11);
         OP_WFIN, OP_BFIN, OP_AV1, OP_AV2: acc_in = mul_res;
         OP_EMIT: begin
            hash_in     = acc_ff ^ (acc_ff >> 16);
            lanes_in[0] = seed_ff + PRIME1 + PRIME2;
            lanes_in[1] = seed_ff + PRIME2;
            lanes_in[2] = seed_ff;
            lanes_in[3] = seed_ff - PRIME1;
            fill_in     = 4'd0;
            len_in      = 32'd0;
            long_in     = 1'b0;
         end
         default: ;
      endcase

      // Seed write; reload lanes only before the first byte of a message
      if (csr_write_enable) begin
         seed_in = csr_write_data;
         if (fresh) begin
            lanes_in[0] = csr_write_data + PRIME1 + PRIME2;
            lanes_in[1] = csr_write_data + PRIME2;
            lanes_in[2] = csr_write_data;
            lanes_in[3] = csr_write_data - PRIME1;
         end
      end
   end

   // Control-like state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= 32'd0;
         lanes_ff[0] <= PRIME1 + PRIME2;
         lanes_ff[1] <= PRIME2;
         lanes_ff[2] <= 32'd0;
         lanes_ff[3] <= 32'd0 - PRIME1;
         fill_ff     <= 4'd0;
         len_ff      <= 32'd0;
         long_ff     <= 1'b0;
      end else begin
         seed_ff <= seed_in;
         for (int i = 0; i < LANE_COUNT; i++) lanes_ff[i] <= lanes_in[i];
         fill_ff <= fill_in;
         len_ff  <= len_in;
         long_ff <= long_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      hash_ff <= hash_in;
      if (cmd.op == OP_LOAD) begin
         buf_ff[fill_ff] <= req_data_byte;
      end
   end

   assign status.fill    = fill_ff;
   assign rsp_hash_value = hash_ff;

endmodule

>>> src/sh32_ctrl.sv
// Controller: sequences byte loads, stripe rounds, digest steps and result handoff.
module sh32_ctrl
   import sh32_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_byte_present,
   input  logic            req_end_of_message,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  sh32_status_type status,
   output sh32_cmd_type    cmd
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_LMUL  = 16'h0002,
      S_LADD  = 16'h0004,
      S_LFIN  = 16'h0008,
      S_FOLD1 = 16'h0010,
      S_FOLD2 = 16'h0020,
      S_FOLD3 = 16'h0040,
      S_WMUL  = 16'h0080,
      S_WADD  = 16'h0100,
      S_WFIN  = 16'h0200,
      S_BMUL  = 16'h0400,
      S_BADD  = 16'h0800,
      S_BFIN  = 16'h1000,
      S_AV1   = 16'h2000,
      S_AV2   = 16'h4000,
      S_OUT   = 16'h8000
   } sh32_state_type;

   sh32_state_type state_ff, state_in;
   logic [3:0]     cnt_ff, cnt_in;
   logic           last_ff, last_in;
   logic           valid_ff, valid_in;
   logic           accept;
   logic           can_emit;
   sh32_state_type tail_next;

   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign can_emit = !valid_ff || !rsp_stall;

   // Pick the next leftover step: word, byte, or avalanche
   always_comb begin
      if (cnt_ff[3:2] < status.fill[3:2]) begin
         tail_next = S_WMUL;
      end else if (cnt_ff < status.fill) begin
         tail_next = S_BMUL;
      end else begin
         tail_next = S_AV1;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            cnt_in = 4'd0;
            if (accept) begin
               last_in = req_end_of_message;
               if (req_byte_present) begin
                  cmd.op = OP_LOAD;
               end
               if (req_byte_present && status.fill == 4'hF) begin
                  state_in = S_LMUL;
               end else if (req_end_of_message) begin
                  state_in = S_FOLD1;
               end
            end
         end
         S_LMUL: begin
            cmd.op   = OP_LMUL;
            state_in = S_LADD;
         end
         S_LADD: begin
            cmd.op   = OP_LADD;
            state_in = S_LFIN;
         end
         S_LFIN: begin
            cmd.op = OP_LFIN;
            cnt_in = cnt_ff + 4'd4;
            if (cnt_ff[3:2] != 2'd3) begin
               state_in = S_LMUL;
            end else if (last_ff) begin
               state_in = S_FOLD1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FOLD1: begin
            cmd.op   = OP_FOLD1;
            cnt_in   = 4'd0;
            state_in = S_FOLD2;
         end
         S_FOLD2: begin
            cmd.op   = OP_FOLD2;
            state_in = S_FOLD3;
         end
         S_FOLD3: begin
            cmd.op   = OP_FOLD3;
            state_in = tail_next;
         end
         S_WMUL: begin
            cmd.op   = OP_WMUL;
            cnt_in   = cnt_ff + 4'd4;
            state_in = S_WADD;
         end
         S_WADD: begin
            cmd.op   = OP_WADD;
            state_in = S_WFIN;
         end
         S_WFIN: begin
            cmd.op   = OP_WFIN;
            state_in = tail_next;
         end
         S_BMUL: begin
            cmd.op   = OP_BMUL;
            cnt_in   = cnt_ff + 4'd1;
            state_in = S_BADD;
         end
         S_BADD: begin
            cmd.op   = OP_BADD;
            state_in = S_BFIN;
         end
         S_BFIN: begin
            cmd.op   = OP_BFIN;
            state_in = tail_next;
         end
         S_AV1: begin
            cmd.op   = OP_AV1;
            state_in = S_AV2;
         end
         S_AV2: begin
            cmd.op   = OP_AV2;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register is free
            if (can_emit) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid: set on emit, drop when taken
   always_comb begin
      valid_in = valid_ff;
      if (cmd.op == OP_EMIT) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 4'd0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule
